[rtl/core/cna_pkg.sv]
package cna_pkg;

    localparam int WE     = 32;          // word width of every operand and result part
    localparam int FRAC   = 16;          // fraction bits
    localparam int PW     = 2 * WE;      // full product width
    localparam int SW     = PW + 1;      // signed sum of two products
    localparam int REM_W  = PW + FRAC;   // scaled dividend magnitude
    localparam int QB     = WE + 1;      // quotient bits kept before saturation
    localparam int CMP_W  = PW + QB;     // divisor shifted by the top quotient bit
    localparam int SQ_IT  = WE;          // square root iterations

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CONJ  = 3'd4,
        OP_NEG   = 3'd5,
        OP_SQMAG = 3'd6,
        OP_MAG   = 3'd7
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [WE:0]      lin_re;   // add/sub/conj/neg result, one guard bit
        logic [WE:0]      lin_im;
        logic [SW-1:0]    pr;       // product sum, dividend, or squared magnitude
        logic [SW-1:0]    pi;
        logic             dbz;
        logic [PW-1:0]    den;
        logic [REM_W-1:0] rem_re;
        logic [REM_W-1:0] rem_im;
        logic [QB-1:0]    q_re;
        logic [QB-1:0]    q_im;
        logic             big_re;
        logic             big_im;
        logic [PW-1:0]    sq_s;
        logic [PW-1:0]    sq_res;
    } stage_t;

    typedef struct packed {
        logic          ovf;
        logic [WE-1:0] val;
    } sat_t;

    function automatic logic [SW-1:0] sx(input logic [PW-1:0] p);
        return {p[PW-1], p};
    endfunction

    function automatic logic [SW-1:0] abs_sum(input logic [SW-1:0] v);
        return v[SW-1] ? (SW'(0) - v) : v;
    endfunction

    function automatic logic [WE:0] abs_lin(input logic [WE:0] v);
        return v[WE] ? ((WE+1)'(0) - v) : v;
    endfunction

    // round to nearest, ties away from zero, on a magnitude
    function automatic logic [SW-1:0] rnd(input logic [SW-1:0] m);
        return (m + (SW'(1) << (FRAC - 1))) >> FRAC;
    endfunction

    function automatic sat_t sat(input logic neg, input logic [SW-1:0] mag);
        sat_t          r;
        logic [SW-1:0] lim;
        logic [SW-1:0] tmp;
        lim   = SW'(1) << (WE - 1);
        r.ovf = 1'b0;
        tmp   = SW'(0) - mag;
        if (neg)
        begin
            if (mag > lim)
            begin
                r.ovf = 1'b1;
                r.val = {1'b1, {(WE-1){1'b0}}};
            end
            else
            begin
                r.val = tmp[WE-1:0];
            end
        end
        else if (mag > lim - SW'(1))
        begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(WE-1){1'b1}}};
        end
        else
        begin
            r.val = mag[WE-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/cna_front.sv]
module cna_front
    import cna_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2:0]           operation,
    input  logic signed [WE-1:0] a_re,
    input  logic signed [WE-1:0] a_im,
    input  logic signed [WE-1:0] b_re,
    input  logic signed [WE-1:0] b_im,
    output logic                 out_valid,
    output stage_t               out_stage
);

    // stage 1: products and linear ops
    logic          v1_reg;
    op_t           op1_reg;
    logic [WE:0]   lin_re1_reg, lin_im1_reg;
    logic [WE:0]   lin_re1_next, lin_im1_next;
    logic [PW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic [PW-1:0] p_aar_reg, p_aai_reg, p_bbr_reg, p_bbi_reg;
    logic signed [PW-1:0] p_rr_next, p_ii_next, p_ir_next, p_ri_next;
    logic signed [PW-1:0] p_aar_next, p_aai_next, p_bbr_next, p_bbi_next;
    logic [WE:0]   ar, ai, br, bi;
    op_t           op_in;

    // stage 2: sums
    logic          v2_reg;
    op_t           op2_reg;
    logic [WE:0]   lin_re2_reg, lin_im2_reg;
    logic [SW-1:0] pr2_reg, pi2_reg, pr2_next, pi2_next;
    logic [PW-1:0] den2_reg;

    // stage 3: division and root setup
    logic          v3_reg;
    stage_t        st3_reg, st3_next;
    logic [SW-1:0] mag_re, mag_im;

    assign op_in = op_t'(operation);
    assign ar = {a_re[WE-1], a_re};
    assign ai = {a_im[WE-1], a_im};
    assign br = {b_re[WE-1], b_re};
    assign bi = {b_im[WE-1], b_im};

    assign p_rr_next  = a_re * b_re;
    assign p_ii_next  = a_im * b_im;
    assign p_ir_next  = a_im * b_re;
    assign p_ri_next  = a_re * b_im;
    assign p_aar_next = a_re * a_re;
    assign p_aai_next = a_im * a_im;
    assign p_bbr_next = b_re * b_re;
    assign p_bbi_next = b_im * b_im;

    always_comb
    begin
        lin_re1_next = ar;
        lin_im1_next = ai;
        unique case (op_in)
            OP_ADD:
            begin
                lin_re1_next = ar + br;
                lin_im1_next = ai + bi;
            end
            OP_SUB:
            begin
                lin_re1_next = ar - br;
                lin_im1_next = ai - bi;
            end
            OP_CONJ:
            begin
                lin_im1_next = (WE+1)'(0) - ai;
            end
            OP_NEG:
            begin
                lin_re1_next = (WE+1)'(0) - ar;
                lin_im1_next = (WE+1)'(0) - ai;
            end
            default:
            begin
                lin_re1_next = ar;
                lin_im1_next = ai;
            end
        endcase
    end

    always_comb
    begin
        pr2_next = '0;
        pi2_next = '0;
        unique case (op1_reg)
            OP_MUL:
            begin
                pr2_next = sx(p_rr_reg) - sx(p_ii_reg);
                pi2_next = sx(p_ir_reg) + sx(p_ri_reg);
            end
            OP_DIV:
            begin
                pr2_next = sx(p_rr_reg) + sx(p_ii_reg);
                pi2_next = sx(p_ir_reg) - sx(p_ri_reg);
            end
            OP_SQMAG, OP_MAG:
            begin
                pr2_next = sx(p_aar_reg) + sx(p_aai_reg);
            end
            default:
            begin
                pr2_next = '0;
                pi2_next = '0;
            end
        endcase
    end

    assign mag_re = abs_sum(pr2_reg);
    assign mag_im = abs_sum(pi2_reg);

    always_comb
    begin
        st3_next        = '0;
        st3_next.op     = op2_reg;
        st3_next.lin_re = lin_re2_reg;
        st3_next.lin_im = lin_im2_reg;
        st3_next.pr     = pr2_reg;
        st3_next.pi     = pi2_reg;
        st3_next.den    = den2_reg;
        st3_next.dbz    = (op2_reg == OP_DIV) && (den2_reg == '0);
        st3_next.rem_re = {mag_re[PW-1:0], {FRAC{1'b0}}};
        st3_next.rem_im = {mag_im[PW-1:0], {FRAC{1'b0}}};
        // quotient too large for the kept bits: saturates anyway
        st3_next.big_re = {{(CMP_W-REM_W){1'b0}}, st3_next.rem_re}
                          >= {den2_reg, {QB{1'b0}}};
        st3_next.big_im = {{(CMP_W-REM_W){1'b0}}, st3_next.rem_im}
                          >= {den2_reg, {QB{1'b0}}};
        st3_next.sq_s   = pr2_reg[PW-1:0];
        st3_next.sq_res = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg     <= op_in;
            lin_re1_reg <= lin_re1_next;
            lin_im1_reg <= lin_im1_next;
            p_rr_reg    <= p_rr_next;
            p_ii_reg    <= p_ii_next;
            p_ir_reg    <= p_ir_next;
            p_ri_reg    <= p_ri_next;
            p_aar_reg   <= p_aar_next;
            p_aai_reg   <= p_aai_next;
            p_bbr_reg   <= p_bbr_next;
            p_bbi_reg   <= p_bbi_next;

            op2_reg     <= op1_reg;
            lin_re2_reg <= lin_re1_reg;
            lin_im2_reg <= lin_im1_reg;
            pr2_reg     <= pr2_next;
            pi2_reg     <= pi2_next;
            den2_reg    <= p_bbr_reg + p_bbi_reg;

            st3_reg     <= st3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_stage = st3_reg;

endmodule

[rtl/core/cna_step.sv]
module cna_step
    import cna_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   out_valid,
    output stage_t out_stage
);

    localparam int SH     = QB - 1 - STEP;
    localparam int SQ_BIT = 2 * WE - 2 - 2 * STEP;

    logic       v_reg;
    stage_t     st_reg, st_next;
    logic [CMP_W-1:0] trial;
    logic [PW-1:0]    sq_bit, sq_sum;

    assign trial = {{(CMP_W-PW){1'b0}}, in_stage.den} << SH;

    generate
        if (STEP < SQ_IT)
        begin : g_sq
            assign sq_bit = PW'(1) << SQ_BIT;
        end
        else
        begin : g_nosq
            assign sq_bit = '0;
        end
    endgenerate

    assign sq_sum = in_stage.sq_res + sq_bit;

    always_comb
    begin
        st_next = in_stage;
        // one restoring division bit for each part
        if ({{(CMP_W-REM_W){1'b0}}, in_stage.rem_re} >= trial)
        begin
            st_next.rem_re   = in_stage.rem_re - trial[REM_W-1:0];
            st_next.q_re[SH] = 1'b1;
        end
        if ({{(CMP_W-REM_W){1'b0}}, in_stage.rem_im} >= trial)
        begin
            st_next.rem_im   = in_stage.rem_im - trial[REM_W-1:0];
            st_next.q_im[SH] = 1'b1;
        end
        // one square root iteration
        if (STEP < SQ_IT)
        begin
            if (in_stage.sq_s >= sq_sum)
            begin
                st_next.sq_s   = in_stage.sq_s - sq_sum;
                st_next.sq_res = (in_stage.sq_res >> 1) + sq_bit;
            end
            else
            begin
                st_next.sq_res = in_stage.sq_res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = v_reg;
    assign out_stage = st_reg;

endmodule

[rtl/core/cna_sat.sv]
module cna_sat
    import cna_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  stage_t               in_stage,
    output logic                 out_valid,
    output logic signed [WE-1:0] res_re,
    output logic signed [WE-1:0] res_im,
    output logic                 overflow,
    output logic                 divide_by_zero
);

    logic          valid_reg;
    logic [WE-1:0] re_reg, im_reg, re_next, im_next;
    logic          ovf_reg, ovf_next, dbz_reg;
    logic          neg_re, neg_im;
    logic [SW-1:0] m_re, m_im;
    sat_t          s_re, s_im;

    always_comb
    begin
        neg_re = 1'b0;
        neg_im = 1'b0;
        m_re   = '0;
        m_im   = '0;
        unique case (in_stage.op)
            OP_ADD, OP_SUB, OP_CONJ, OP_NEG:
            begin
                neg_re = in_stage.lin_re[WE];
                neg_im = in_stage.lin_im[WE];
                m_re   = SW'(abs_lin(in_stage.lin_re));
                m_im   = SW'(abs_lin(in_stage.lin_im));
            end
            OP_MUL:
            begin
                neg_re = in_stage.pr[SW-1];
                neg_im = in_stage.pi[SW-1];
                m_re   = rnd(abs_sum(in_stage.pr));
                m_im   = rnd(abs_sum(in_stage.pi));
            end
            OP_DIV:
            begin
                neg_re = in_stage.pr[SW-1];
                neg_im = in_stage.pi[SW-1];
                m_re   = in_stage.big_re ? (SW'(1) << QB) : SW'(in_stage.q_re);
                m_im   = in_stage.big_im ? (SW'(1) << QB) : SW'(in_stage.q_im);
            end
            OP_SQMAG:
            begin
                m_re = rnd(in_stage.pr);
            end
            OP_MAG:
            begin
                m_re = SW'(in_stage.sq_res);
            end
            default:
            begin
                m_re = '0;
            end
        endcase
        s_re = sat(neg_re, m_re);
        s_im = sat(neg_im, m_im);
        if (in_stage.dbz)
        begin
            re_next  = '0;
            im_next  = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            re_next  = s_re.val;
            im_next  = s_im.val;
            ovf_next = s_re.ovf | s_im.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
            dbz_reg <= in_stage.dbz;
        end
    end

    assign out_valid      = valid_reg;
    assign res_re         = re_reg;
    assign res_im         = im_reg;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dbz_reg;

endmodule

[rtl/core/complex_number_alu.sv]
// pipeline from an accepted word to its result: 3 front stages for products,
// sums and divider setup, 33 divide/root stages, 1 output stage
// throughput: one word per cycle; the whole pipeline holds while a result waits
// reset: rst_n asynchronous active low clears all valid bits, pipeline empty
module complex_number_alu
    import cna_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           operation,
    input  logic signed [WE-1:0] a_re,
    input  logic signed [WE-1:0] a_im,
    input  logic signed [WE-1:0] b_re,
    input  logic signed [WE-1:0] b_im,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [WE-1:0] res_re,
    output logic signed [WE-1:0] res_im,
    output logic                 overflow,
    output logic                 divide_by_zero
);

    logic   en;
    logic   pv [0:QB];
    stage_t pipe [0:QB];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    cna_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .operation (operation),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (pv[0]),
        .out_stage (pipe[0])
    );

    generate
        for (genvar k = 0; k < QB; k++)
        begin : g_step
            cna_step #(.STEP(k)) u_step
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (pv[k]),
                .in_stage  (pipe[k]),
                .out_valid (pv[k+1]),
                .out_stage (pipe[k+1])
            );
        end
    endgenerate

    cna_sat u_sat
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (pv[QB]),
        .in_stage       (pipe[QB]),
        .out_valid      (out_valid),
        .res_re         (res_re),
        .res_im         (res_im),
        .overflow       (overflow),
        .divide_by_zero (divide_by_zero)
    );

endmodule

[rtl/core/cna_checker.sv]
module cna_checker
    import cna_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [2:0]           operation,
    input logic signed [WE-1:0] a_re,
    input logic signed [WE-1:0] a_im,
    input logic signed [WE-1:0] b_re,
    input logic signed [WE-1:0] b_im,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [WE-1:0] res_re,
    input logic signed [WE-1:0] res_im,
    input logic                 overflow,
    input logic                 divide_by_zero
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im))
        else $error("result word changed while stalled");

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
        else $error("divide by zero word is not zero");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind complex_number_alu cna_checker u_cna_checker (.*);
